### design/hcb_pkg.sv
package hcb_pkg;

	localparam int HDR_WORDS = 6;
	localparam logic [5:0] HDR_MAX = 6'd48;
	localparam logic [3:0] LEN_MIN = 4'd3;
	localparam logic [3:0] LEN_CAP = 4'd13;
	localparam logic [3:0] MAX_LEN_RESET = 4'd13;
	localparam int CTR_W = 61;
	localparam int IDX_W = 60;

	localparam logic [7:0] PAD_BYTE = 8'h80;
	localparam logic [7:0] SYM_SLASH = 8'h2F;
	localparam logic [7:0] SYM_PLUS = 8'h2B;
	localparam logic [7:0] SYM_DIGIT = 8'h30;
	localparam logic [7:0] SYM_LOWER = 8'h61;
	localparam logic [7:0] SYM_UPPER = 8'h41;

	// register indexes on the configuration port
	localparam logic [2:0] REG_HDR_LEN = 3'd0;
	localparam logic [2:0] REG_MAX_LEN = 3'd1;
	localparam logic [2:0] REG_HDR0 = 3'd2;
	localparam logic [2:0] REG_HDR1 = 3'd3;
	localparam logic [2:0] REG_HDR2 = 3'd4;
	localparam logic [2:0] REG_HDR3 = 3'd5;
	localparam logic [2:0] REG_HDR4 = 3'd6;
	localparam logic [2:0] REG_HDR5 = 3'd7;

	// base-64 digit to character: / + 0-9 a-z A-Z
	function automatic logic [7:0] sym_of(input logic [5:0] d);
		logic [7:0] v;
		if (d == 6'd0) begin
			v = SYM_SLASH;
		end else if (d == 6'd1) begin
			v = SYM_PLUS;
		end else if (d < 6'd12) begin
			v = SYM_DIGIT + {2'b00, d} - 8'd2;
		end else if (d < 6'd38) begin
			v = SYM_LOWER + {2'b00, d} - 8'd12;
		end else begin
			v = SYM_UPPER + {2'b00, d} - 8'd38;
		end
		return v;
	endfunction

endpackage

### design/hcb_req_if.sv
interface hcb_req_if;
	logic valid;
	logic ready;
	logic request;

	modport source (output valid, output request, input ready);
	modport sink (input valid, input request, output ready);
endinterface

### design/hcb_res_if.sv
interface hcb_res_if;
	logic valid;
	logic ready;
	logic [63:0] payload_word;
	logic word_last;
	logic exhausted;
	logic [3:0] cand_length;
	logic [3:0] hole_high;
	logic [3:0] hole_mid;
	logic [3:0] hole_low;
	logic [59:0] product_index;

	modport source (output valid, output payload_word, output word_last, output exhausted,
		output cand_length, output hole_high, output hole_mid, output hole_low,
		output product_index, input ready);
	modport sink (input valid, input payload_word, input word_last, input exhausted,
		input cand_length, input hole_high, input hole_mid, input hole_low,
		input product_index, output ready);
endinterface

### design/hash_candidate_block_generator.sv
// Brute-force candidate source for a hash core. Each accepted request with request set
// yields the next candidate as one padded 64-byte block in eight 64-bit beats (byte 8k+j
// in bits 8j+7:8j of beat k), walking suffix lengths from 3 up to max_length, every
// descending choice of three hole positions and every base-64 product index. Once the
// lengths are used up a request gets a single beat with exhausted and word_last set; the
// position is kept, so raising max_length resumes; a max_length above 13 counts as 13.
// A request advances the position, loads the header, padding and length bytes,
// lets one shared shift-and-symbol unit place the suffix bytes one position at a
// time, sends the eight beats and returns to idle, where the next request is taken.
// An exhausted request sends its single beat and returns to idle. A request with
// request clear is taken and dropped. The block is ready only between candidates;
// configuration is to be written by the user only while it is idle, which the
// block does not enforce. Registers sit at byte address 8*i, 64 bits wide.
module hash_candidate_block_generator (
	input  logic             clk,
	input  logic             arst_n,
	hcb_req_if.sink          cand_req,
	hcb_res_if.source        cand_out,
	input  logic             psel,
	input  logic             penable,
	input  logic             pwrite,
	input  logic [5:0]       paddr,
	input  logic [63:0]      pwdata,
	output logic [63:0]      prdata,
	output logic             pready
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ADVANCE,
		ST_PREP,
		ST_FILL,
		ST_SEND,
		ST_EXH
	} state_t;

	state_t state_q;

	// configuration
	logic [5:0]  hlen_q;
	logic [3:0]  max_q;
	logic [63:0] hdr_q [hcb_pkg::HDR_WORDS];

	// enumeration position
	logic [3:0]                 len_q;
	logic [3:0]                 h0_q;
	logic [3:0]                 h1_q;
	logic [3:0]                 h2_q;
	logic [hcb_pkg::CTR_W-1:0]  ctr_q;
	logic [hcb_pkg::CTR_W-1:0]  lim_q;

	// per-candidate work
	logic [hcb_pkg::IDX_W-1:0]  idx_q;
	logic [hcb_pkg::IDX_W-1:0]  acc_q;
	logic [3:0]                 pos_q;
	logic [2:0]                 word_q;
	logic [63:0]                blk_q [8];

	logic [3:0]   eff_max;
	logic [5:0]   hl;
	logic [6:0]   total;
	logic [9:0]   bits;
	logic [511:0] hdr_ext;
	logic [7:0]   byte_v;
	logic [63:0]  base_img [8];
	logic [5:0]   wr_addr;
	logic         is_hole;
	logic         req_fire;
	logic         out_fire;
	logic         cfg_wr;

	assign pready   = 1'b1;
	assign cfg_wr   = psel && penable && pwrite;
	assign req_fire = cand_req.valid && cand_req.ready;
	assign out_fire = cand_out.valid && cand_out.ready;

	assign eff_max = (max_q > hcb_pkg::LEN_CAP) ? hcb_pkg::LEN_CAP : max_q;
	assign hl      = (hlen_q > hcb_pkg::HDR_MAX) ? hcb_pkg::HDR_MAX : hlen_q;
	assign total   = {1'b0, hl} + {3'b000, len_q};
	assign bits    = {total, 3'b000};
	assign hdr_ext = {128'd0, hdr_q[5], hdr_q[4], hdr_q[3], hdr_q[2], hdr_q[1], hdr_q[0]};
	assign wr_addr = hl + {2'b00, pos_q};
	assign is_hole = (pos_q == h0_q) || (pos_q == h1_q) || (pos_q == h2_q);

	// header, pad byte and bit length, one lane per block byte
	always_comb begin
		byte_v = 8'h00;
		for (int k = 0; k < 8; k++) begin
			base_img[k] = 64'd0;
		end
		for (int p = 0; p < 64; p++) begin
			byte_v = 8'h00;
			if (7'(p) < {1'b0, hl}) begin
				byte_v = hdr_ext[p*8 +: 8];
			end else if (p == 62) begin
				byte_v = {6'b000000, bits[9:8]};
			end else if (p == 63) begin
				byte_v = bits[7:0];
			end else if (7'(p) == total) begin
				byte_v = hcb_pkg::PAD_BYTE;
			end
			base_img[p >> 3][(p & 7)*8 +: 8] = byte_v;
		end
	end

	// configuration port
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hlen_q <= 6'd0;
			max_q  <= hcb_pkg::MAX_LEN_RESET;
			for (int w = 0; w < hcb_pkg::HDR_WORDS; w++) begin
				hdr_q[w] <= 64'd0;
			end
		end else if (cfg_wr) begin
			case (paddr[5:3])
				hcb_pkg::REG_HDR_LEN: hlen_q   <= pwdata[5:0];
				hcb_pkg::REG_MAX_LEN: max_q    <= pwdata[3:0];
				hcb_pkg::REG_HDR0:    hdr_q[0] <= pwdata;
				hcb_pkg::REG_HDR1:    hdr_q[1] <= pwdata;
				hcb_pkg::REG_HDR2:    hdr_q[2] <= pwdata;
				hcb_pkg::REG_HDR3:    hdr_q[3] <= pwdata;
				hcb_pkg::REG_HDR4:    hdr_q[4] <= pwdata;
				hcb_pkg::REG_HDR5:    hdr_q[5] <= pwdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[5:3])
			hcb_pkg::REG_HDR_LEN: prdata = {58'd0, hlen_q};
			hcb_pkg::REG_MAX_LEN: prdata = {60'd0, max_q};
			hcb_pkg::REG_HDR0:    prdata = hdr_q[0];
			hcb_pkg::REG_HDR1:    prdata = hdr_q[1];
			hcb_pkg::REG_HDR2:    prdata = hdr_q[2];
			hcb_pkg::REG_HDR3:    prdata = hdr_q[3];
			hcb_pkg::REG_HDR4:    prdata = hdr_q[4];
			hcb_pkg::REG_HDR5:    prdata = hdr_q[5];
			default:              prdata = 64'd0;
		endcase
	end

	// block image: loaded whole, then one suffix position per cycle, holes left as loaded
	always_ff @(posedge clk) begin
		if (state_q == ST_PREP) begin
			for (int k = 0; k < 8; k++) begin
				blk_q[k] <= base_img[k];
			end
		end else if (state_q == ST_FILL && !is_hole) begin
			blk_q[wr_addr[5:3]][{wr_addr[2:0], 3'b000} +: 8] <= hcb_pkg::sym_of(acc_q[5:0]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			len_q   <= hcb_pkg::LEN_MIN;
			h0_q    <= 4'd2;
			h1_q    <= 4'd1;
			h2_q    <= 4'd0;
			ctr_q   <= '0;
			lim_q   <= hcb_pkg::CTR_W'(1);
			idx_q   <= '0;
			acc_q   <= '0;
			pos_q   <= 4'd0;
			word_q  <= 3'd0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (req_fire && cand_req.request) begin
						state_q <= ST_ADVANCE;
					end
				end
				ST_ADVANCE: begin
					if (len_q <= eff_max && ctr_q == lim_q) begin
						ctr_q <= '0;
						if ({1'b0, h0_q} + 5'd1 < {1'b0, len_q}) begin
							h0_q <= h0_q + 4'd1;
						end else if ({1'b0, h1_q} + 5'd2 < {1'b0, len_q}) begin
							h1_q <= h1_q + 4'd1;
							h0_q <= h1_q + 4'd2;
						end else if ({1'b0, h2_q} + 5'd3 < {1'b0, len_q}) begin
							h2_q <= h2_q + 4'd1;
							h1_q <= h2_q + 4'd2;
							h0_q <= h2_q + 4'd3;
						end else begin
							// every hole choice used: next length
							h0_q  <= 4'd2;
							h1_q  <= 4'd1;
							h2_q  <= 4'd0;
							len_q <= len_q + 4'd1;
							lim_q <= {lim_q[hcb_pkg::CTR_W-7:0], 6'b000000};
						end
					end
					state_q <= ST_PREP;
				end
				ST_PREP: begin
					if (len_q > eff_max) begin
						state_q <= ST_EXH;
					end else begin
						idx_q   <= ctr_q[hcb_pkg::IDX_W-1:0];
						acc_q   <= ctr_q[hcb_pkg::IDX_W-1:0];
						ctr_q   <= ctr_q + hcb_pkg::CTR_W'(1);
						pos_q   <= 4'd0;
						state_q <= ST_FILL;
					end
				end
				ST_FILL: begin
					if (!is_hole) begin
						acc_q <= acc_q >> 6;
					end
					pos_q <= pos_q + 4'd1;
					if (pos_q == len_q - 4'd1) begin
						word_q  <= 3'd0;
						state_q <= ST_SEND;
					end
				end
				ST_SEND: begin
					if (out_fire) begin
						word_q <= word_q + 3'd1;
						if (word_q == 3'd7) begin
							state_q <= ST_IDLE;
						end
					end
				end
				ST_EXH: begin
					if (out_fire) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign cand_req.ready = (state_q == ST_IDLE);

	assign cand_out.valid         = (state_q == ST_SEND) || (state_q == ST_EXH);
	assign cand_out.payload_word  = (state_q == ST_SEND) ? blk_q[word_q] : 64'd0;
	assign cand_out.word_last     = (state_q == ST_EXH) ||
		((state_q == ST_SEND) && (word_q == 3'd7));
	assign cand_out.exhausted     = (state_q == ST_EXH);
	assign cand_out.cand_length   = (state_q == ST_SEND) ? len_q : 4'd0;
	assign cand_out.hole_high     = (state_q == ST_SEND) ? h0_q : 4'd0;
	assign cand_out.hole_mid      = (state_q == ST_SEND) ? h1_q : 4'd0;
	assign cand_out.hole_low      = (state_q == ST_SEND) ? h2_q : 4'd0;
	assign cand_out.product_index = (state_q == ST_SEND) ? idx_q : '0;

`ifndef SYNTH
	// no new request while a block is on its way out
	a_busy_while_out: assert property (@(posedge clk) disable iff (!arst_n)
		cand_out.valid |-> !cand_req.ready)
		else $error("request taken while a result beat is pending");

	// a block is only sent for a length inside the enumerated range
	a_len_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SEND) |-> (len_q >= hcb_pkg::LEN_MIN && len_q <= eff_max))
		else $error("candidate length outside enumerated range");

	// holes stay strictly descending and inside the suffix
	a_holes_order: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SEND) |-> (h0_q > h1_q && h1_q > h2_q && h0_q < len_q))
		else $error("hole positions out of order");

	// the beat counter starts every block at word zero
	a_first_word: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SEND && $past(state_q) == ST_FILL) |-> (word_q == 3'd0))
		else $error("block did not start at word zero");

	// last beat of a block returns the block to idle
	a_last_to_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(out_fire && cand_out.word_last) |=> (state_q == ST_IDLE))
		else $error("block not idle after last beat");
`endif

endmodule

### tb/sv/tb_top.sv
module tb_top;

	localparam int CYCLE_LIMIT = 300000;
	localparam int QUIET_CYCLES = 40;
	localparam int HOLD_CYCLES = 150;

	typedef struct packed {
		logic [63:0] payload_word;
		logic        word_last;
		logic        exhausted;
		logic [3:0]  cand_length;
		logic [3:0]  hole_high;
		logic [3:0]  hole_mid;
		logic [3:0]  hole_low;
		logic [59:0] product_index;
	} beat_t;

	logic        clk;
	logic        arst_n;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [5:0]  paddr;
	logic [63:0] pwdata;
	logic [63:0] prdata;
	logic        pready;

	hcb_req_if cand_req ();
	hcb_res_if cand_out ();

	hash_candidate_block_generator dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cand_req (cand_req),
		.cand_out (cand_out),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	initial clk = 1'b0;
	always #4 clk = ~clk;

	// shadow of the configuration registers
	logic [5:0]  cfg_hdr_len = 6'd0;
	logic [3:0]  cfg_max_len = hcb_pkg::MAX_LEN_RESET;
	logic [63:0] cfg_hdr [hcb_pkg::HDR_WORDS] = '{default: 64'd0};

	// shadow of the enumeration position
	logic [3:0]  cur_len = hcb_pkg::LEN_MIN;
	logic [3:0]  holes [3] = '{4'd2, 4'd1, 4'd0};
	logic [60:0] prod_count = '0;
	logic [60:0] prod_limit = 61'd1;
	bit          at_end = 1'b0;

	string symbol_chars = "/+0123456789abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ";

	beat_t expected_words [$];

	int error_count = 0;
	int candidate_count = 0;
	int exhaust_count = 0;
	int dropped_count = 0;
	int setting_count = 0;
	int beats_checked = 0;
	int cycle_count = 0;
	int hold_request = 0;
	bit src_idle_on = 1'b1;
	bit sink_idle_on = 1'b1;

	function automatic logic [3:0] max_len_eff();
		return (cfg_max_len > hcb_pkg::LEN_CAP) ? hcb_pkg::LEN_CAP : cfg_max_len;
	endfunction

	// next descending hole choice for the current length, 0 when all are used
	function automatic bit next_holes();
		int i;
		int j;
		for (i = 0; i < 3; i++) begin
			if (int'(holes[i]) + i + 1 >= int'(cur_len))
				continue;
			holes[i] = holes[i] + 4'd1;
			for (j = 0; j < i; j++)
				holes[j] = 4'(int'(holes[i]) + i - j);
			return 1'b1;
		end
		return 1'b0;
	endfunction

	function automatic void predict_candidate(input bit req);
		logic [7:0]  blk [64];
		logic [60:0] idx;
		logic [60:0] acc;
		logic [5:0]  hl_eff;
		logic [63:0] w;
		beat_t       b;
		int          hl;
		int          total;
		int          bits;
		int          i;
		int          k;
		if (!req) begin
			dropped_count++;
			return;
		end
		if (cur_len <= max_len_eff() && prod_count == prod_limit) begin
			prod_count = '0;
			if (!next_holes()) begin
				holes = '{4'd2, 4'd1, 4'd0};
				cur_len = cur_len + 4'd1;
				prod_limit = prod_limit << 6;
			end
		end
		if (cur_len > max_len_eff()) begin
			at_end = 1'b1;
			b = '0;
			b.word_last = 1'b1;
			b.exhausted = 1'b1;
			expected_words.push_back(b);
			exhaust_count++;
			return;
		end
		at_end = 1'b0;
		idx = prod_count;
		prod_count = prod_count + 61'd1;
		hl_eff = (cfg_hdr_len > hcb_pkg::HDR_MAX) ? hcb_pkg::HDR_MAX : cfg_hdr_len;
		hl = int'(hl_eff);
		for (i = 0; i < 64; i++)
			blk[i] = 8'h00;
		for (i = 0; i < hl; i++)
			blk[i] = cfg_hdr[i / 8][(i % 8) * 8 +: 8];
		total = hl + int'(cur_len);
		blk[total % 64] = hcb_pkg::PAD_BYTE;
		bits = total * 8;
		blk[62] = 8'(bits / 256);
		blk[63] = 8'(bits % 256);
		// free positions take index digits, least significant first
		acc = idx;
		for (i = 0; i < int'(cur_len); i++) begin
			if (holes[0] == i || holes[1] == i || holes[2] == i)
				continue;
			blk[(hl + i) % 64] = symbol_chars[int'(acc[5:0])];
			acc = acc >> 6;
		end
		for (k = 0; k < 8; k++) begin
			for (i = 0; i < 8; i++)
				w[i * 8 +: 8] = blk[k * 8 + i];
			b.payload_word = w;
			b.word_last = (k == 7);
			b.exhausted = 1'b0;
			b.cand_length = cur_len;
			b.hole_high = holes[0];
			b.hole_mid = holes[1];
			b.hole_low = holes[2];
			b.product_index = idx[59:0];
			expected_words.push_back(b);
		end
		candidate_count++;
	endfunction

	task automatic report_mismatch(input string msg);
		$display("mismatch at cycle %0d: %s", cycle_count, msg);
		error_count++;
	endtask

	task automatic compare_field(input string name, input logic [63:0] got,
			input logic [63:0] want);
		if (got !== want)
			report_mismatch($sformatf("%s got %h want %h", name, got, want));
	endtask

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
	end

	initial begin
		wait (cycle_count >= CYCLE_LIMIT);
		$display("timeout with %0d beats outstanding", expected_words.size());
		$display("hash_candidate_block_generator verification failed");
		$finish;
	end

	always @(posedge clk) begin : result_check
		beat_t want;
		if (arst_n && cand_out.valid && cand_out.ready) begin
			beats_checked++;
			if (expected_words.size() == 0) begin
				report_mismatch($sformatf("beat %h with nothing outstanding",
					cand_out.payload_word));
			end else begin
				want = expected_words.pop_front();
				compare_field("payload_word", cand_out.payload_word, want.payload_word);
				compare_field("word_last", 64'(cand_out.word_last), 64'(want.word_last));
				compare_field("exhausted", 64'(cand_out.exhausted), 64'(want.exhausted));
				compare_field("cand_length", 64'(cand_out.cand_length),
					64'(want.cand_length));
				compare_field("hole_high", 64'(cand_out.hole_high), 64'(want.hole_high));
				compare_field("hole_mid", 64'(cand_out.hole_mid), 64'(want.hole_mid));
				compare_field("hole_low", 64'(cand_out.hole_low), 64'(want.hole_low));
				compare_field("product_index", 64'(cand_out.product_index),
					64'(want.product_index));
			end
		end
	end

	// output side: random stall bursts, or one long hold when asked
	initial begin : sink_ready
		int n;
		cand_out.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_request > 0) begin
				n = hold_request;
				hold_request = 0;
				cand_out.ready <= 1'b0;
				repeat (n - 1) @(negedge clk);
			end else if (sink_idle_on && $urandom_range(0, 5) == 0) begin
				cand_out.ready <= 1'b0;
				repeat ($urandom_range(0, 3)) @(negedge clk);
			end else begin
				cand_out.ready <= 1'b1;
			end
		end
	end

	// valid is left high after the beat so back-to-back requests need no gap
	task automatic send_request(input bit req);
		int gap;
		@(negedge clk);
		if (src_idle_on && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 4);
			cand_req.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		cand_req.valid <= 1'b1;
		cand_req.request <= req;
		do @(posedge clk); while (!cand_req.ready);
		predict_candidate(req);
	endtask

	task automatic wait_for_idle();
		@(negedge clk);
		cand_req.valid <= 1'b0;
		while (expected_words.size() != 0)
			@(posedge clk);
		// a dropped request may still be in flight
		repeat (QUIET_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [2:0] idx, input logic [63:0] val);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 3'b000};
		pwdata <= val;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		case (idx)
			hcb_pkg::REG_HDR_LEN: cfg_hdr_len = val[5:0];
			hcb_pkg::REG_MAX_LEN: cfg_max_len = val[3:0];
			default: cfg_hdr[int'(idx) - int'(hcb_pkg::REG_HDR0)] = val;
		endcase
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic check_reg(input logic [2:0] idx);
		logic [63:0] got;
		logic [63:0] want;
		logic [63:0] mask;
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= {idx, 3'b000};
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		got = prdata;
		case (idx)
			hcb_pkg::REG_HDR_LEN: begin
				want = {58'd0, cfg_hdr_len};
				mask = 64'h3F;
			end
			hcb_pkg::REG_MAX_LEN: begin
				want = {60'd0, cfg_max_len};
				mask = 64'hF;
			end
			default: begin
				want = cfg_hdr[int'(idx) - int'(hcb_pkg::REG_HDR0)];
				mask = '1;
			end
		endcase
		compare_field($sformatf("register %0d readback", idx), got & mask, want & mask);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	function automatic logic [63:0] rand_word();
		case ($urandom_range(0, 3))
			0: return '0;
			1: return '1;
			default: return {$urandom, $urandom};
		endcase
	endfunction

	task automatic load_random_header();
		logic [5:0] hl;
		int w;
		case ($urandom_range(0, 5))
			0: hl = 6'd0;
			1: hl = hcb_pkg::HDR_MAX;
			2: hl = 6'd63;
			default: hl = 6'($urandom_range(0, 63));
		endcase
		write_reg(hcb_pkg::REG_HDR_LEN, {58'd0, hl});
		for (w = 0; w < hcb_pkg::HDR_WORDS; w++)
			write_reg(3'(int'(hcb_pkg::REG_HDR0) + w), rand_word());
		setting_count++;
	endtask

	// length three has a single candidate, then length four starts
	task automatic test_first_candidates();
		send_request(1'b1);
		send_request(1'b1);
		send_request(1'b0);
		send_request(1'b1);
		wait_for_idle();
	endtask

	task automatic test_register_access();
		int i;
		for (i = 0; i < 8; i++)
			check_reg(3'(i));
		write_reg(hcb_pkg::REG_HDR_LEN, 64'd63);
		write_reg(hcb_pkg::REG_MAX_LEN, 64'd15);
		for (i = 0; i < hcb_pkg::HDR_WORDS; i++)
			write_reg(3'(int'(hcb_pkg::REG_HDR0) + i), {$urandom, $urandom});
		for (i = 0; i < 8; i++)
			check_reg(3'(i));
		write_reg(hcb_pkg::REG_HDR_LEN, 64'd0);
		write_reg(hcb_pkg::REG_MAX_LEN, 64'd13);
		for (i = 0; i < 8; i++)
			check_reg(3'(i));
	endtask

	task automatic test_header_extremes();
		int i;
		// full header of ones against the suffix and padding
		write_reg(hcb_pkg::REG_HDR_LEN, {58'd0, hcb_pkg::HDR_MAX});
		for (i = 0; i < hcb_pkg::HDR_WORDS; i++)
			write_reg(3'(int'(hcb_pkg::REG_HDR0) + i), '1);
		send_request(1'b1);
		send_request(1'b1);
		wait_for_idle();
		// oversized length clamps to the full header
		write_reg(hcb_pkg::REG_HDR_LEN, 64'd63);
		for (i = 0; i < hcb_pkg::HDR_WORDS; i++)
			write_reg(3'(int'(hcb_pkg::REG_HDR0) + i), {$urandom, $urandom});
		send_request(1'b1);
		send_request(1'b1);
		wait_for_idle();
		write_reg(hcb_pkg::REG_HDR_LEN, 64'd0);
		send_request(1'b1);
		wait_for_idle();
		write_reg(hcb_pkg::REG_HDR_LEN, 64'd47);
		send_request(1'b1);
		wait_for_idle();
		setting_count += 4;
	endtask

	task automatic test_exhaustion();
		write_reg(hcb_pkg::REG_MAX_LEN, 64'd3);
		send_request(1'b1);
		send_request(1'b0);
		send_request(1'b1);
		wait_for_idle();
		write_reg(hcb_pkg::REG_MAX_LEN, 64'd0);
		send_request(1'b1);
		wait_for_idle();
		// oversized maximum counts as the cap and resumes
		write_reg(hcb_pkg::REG_MAX_LEN, 64'd15);
		send_request(1'b1);
		send_request(1'b1);
		wait_for_idle();
		setting_count += 3;
	endtask

	task automatic test_output_hold();
		int i;
		load_random_header();
		hold_request = HOLD_CYCLES;
		for (i = 0; i < 12; i++)
			send_request($urandom_range(0, 7) != 0);
		wait_for_idle();
	endtask

	// run length four to its end so advancing past the maximum exhausts
	task automatic test_length_four_walk();
		int sent;
		int tail;
		write_reg(hcb_pkg::REG_MAX_LEN, 64'd4);
		sent = 0;
		tail = 0;
		while (tail < 3 && sent < 400) begin
			if (sent % 40 == 0) begin
				wait_for_idle();
				load_random_header();
				src_idle_on = ($urandom_range(0, 3) != 0);
				sink_idle_on = ($urandom_range(0, 3) != 0);
			end
			send_request($urandom_range(0, 15) != 0);
			sent++;
			if (at_end)
				tail++;
		end
		wait_for_idle();
	endtask

	task automatic test_resume_longer();
		int i;
		src_idle_on = 1'b1;
		sink_idle_on = 1'b1;
		write_reg(hcb_pkg::REG_MAX_LEN, ($urandom_range(0, 1) != 0) ? 64'd13 : 64'd15);
		load_random_header();
		for (i = 0; i < 24; i++) begin
			if (i == 12) begin
				src_idle_on = 1'b0;
				sink_idle_on = 1'b0;
			end
			send_request($urandom_range(0, 7) != 0);
		end
		wait_for_idle();
	endtask

	initial begin
		arst_n = 1'b0;
		cand_req.valid = 1'b0;
		cand_req.request = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		repeat (4) @(negedge clk);
		arst_n <= 1'b1;
		repeat (2) @(negedge clk);

		test_first_candidates();
		test_register_access();
		test_header_extremes();
		test_exhaustion();
		test_output_hold();
		test_length_four_walk();
		test_resume_longer();

		$display("%0d candidates and %0d exhaustion beats checked (%0d beats), %0d dropped",
			candidate_count, exhaust_count, beats_checked, dropped_count);
		$display("%0d header and length settings, final length %0d", setting_count, cur_len);
		if (error_count == 0) begin
			$display("hash_candidate_block_generator verification clean");
		end else begin
			$display("hash_candidate_block_generator verification failed");
		end
		$finish;
	end

endmodule

### files.f
design/hcb_pkg.sv
design/hcb_req_if.sv
design/hcb_res_if.sv
design/hash_candidate_block_generator.sv
tb/sv/tb_top.sv
